FILE: hdl/strided_tile_pair_address_walker_core_assert.svh
// Assertion macros for the strided tile pair address walker.
`ifndef STRIDED_TILE_PAIR_ADDRESS_WALKER_CORE_ASSERT_SVH
`define STRIDED_TILE_PAIR_ADDRESS_WALKER_CORE_ASSERT_SVH
// Asserts that an antecedent implies a consequent on the next clock edge.
`define STPAW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
// Asserts that a condition holds at every clock edge outside reset.
`define STPAW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

FILE: hdl/stpaw_pkg.sv
// ----------------------------------------------------------------------------
// stpaw_pkg
// Shared constants and types of the strided tile pair address walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package stpaw_pkg;
  localparam int TILE_ID_BITS = 32;
  localparam int DIM_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int IN_BYTES = 33;
  localparam int OUT_BYTES = 8;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BATCH_COUNT   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_ROWS     = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILE_COLS     = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHARD_WIDTH   = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SHARD_MODE    = 3'd6;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Datapath operation selects.
  localparam logic [3:0] OP_NONE    = 4'd0;
  localparam logic [3:0] OP_LOAD    = 4'd1;  // latch start item, deactivate walk
  localparam logic [3:0] OP_SIZE_HW = 4'd2;  // hw = rows * cols
  localparam logic [3:0] OP_SIZE_PB = 4'd3;  // per_batch = hw * channels
  localparam logic [3:0] OP_SIZE_PD = 4'd4;  // per_depth = per_batch * batches
  localparam logic [3:0] OP_DIV_INIT = 4'd5; // load divider with level sel
  localparam logic [3:0] OP_DIV_BIT = 4'd6;  // one quotient bit
  localparam logic [3:0] OP_DIV_DONE = 4'd7; // store quotient, remainder
  localparam logic [3:0] OP_MUL_STEP = 4'd8; // one offset product
  localparam logic [3:0] OP_FINISH  = 4'd9;  // load walk registers
  localparam logic [3:0] OP_STEP    = 4'd10; // emit and advance

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] sel;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic walk_ok;
    logic active;
    logic final_step;
  } status_t;
endpackage
`default_nettype wire

FILE: hdl/stpaw_ctrl.sv
// ----------------------------------------------------------------------------
// stpaw_ctrl
// Sequencer for start setup and step issue of the tile pair walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stpaw_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_fire,
  input  wire logic                 in_kind,
  input  wire logic                 out_free,
  input  wire stpaw_pkg::status_t   status,
  output logic                      in_ready,
  output logic                      out_load,
  output stpaw_pkg::cmd_t           cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SIZE = 3'd1;
  localparam logic [2:0] S_DIVI = 3'd2;
  localparam logic [2:0] S_DIVB = 3'd3;
  localparam logic [2:0] S_DIVD = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd.op = stpaw_pkg::OP_NONE;
    cmd.sel = 3'd0;
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = out_free;
        if (in_fire) begin
          if (in_kind == stpaw_pkg::KIND_START) begin
            cmd.op = stpaw_pkg::OP_LOAD;
            state_next = S_SIZE;
            cnt_next = '0;
          end else if (status.active) begin
            cmd.op = stpaw_pkg::OP_STEP;
            out_load = 1'b1;
          end
        end
      end
      S_SIZE: begin
        cmd.op = (cnt == 4'd0) ? stpaw_pkg::OP_SIZE_HW :
                 (cnt == 4'd1) ? stpaw_pkg::OP_SIZE_PB : stpaw_pkg::OP_SIZE_PD;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd2) begin
          state_next = S_DIVI;
          cnt_next = '0;
        end
      end
      S_DIVI: begin
        cmd.op = stpaw_pkg::OP_DIV_INIT;
        cmd.sel = cnt[2:0];
        state_next = S_DIVB;
      end
      S_DIVB: begin
        cmd.op = stpaw_pkg::OP_DIV_BIT;
        cmd.sel = cnt[2:0];
        if (status.div_last) state_next = S_DIVD;
      end
      S_DIVD: begin
        cmd.op = stpaw_pkg::OP_DIV_DONE;
        cmd.sel = cnt[2:0];
        if (cnt == 4'd3) begin
          state_next = S_MUL;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 4'd1;
          state_next = S_DIVI;
        end
      end
      S_MUL: begin
        cmd.op = stpaw_pkg::OP_MUL_STEP;
        cmd.sel = cnt[2:0];
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd7) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op = stpaw_pkg::OP_FINISH;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: hdl/stpaw_datapath.sv
// ----------------------------------------------------------------------------
// stpaw_datapath
// Shape products, shared restoring divider, offset setup and loop counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module stpaw_datapath #(
  parameter int TILE_ID_BITS = stpaw_pkg::TILE_ID_BITS,
  parameter int DIM_BITS = stpaw_pkg::DIM_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire stpaw_pkg::cmd_t         cmd,
  input  wire logic [DIM_BITS-1:0]     depth_count,
  input  wire logic [DIM_BITS-1:0]     batch_count,
  input  wire logic [DIM_BITS-1:0]     channel_count,
  input  wire logic [DIM_BITS-1:0]     tile_rows,
  input  wire logic [DIM_BITS-1:0]     tile_cols,
  input  wire logic [DIM_BITS-1:0]     shard_width,
  input  wire logic                    shard_mode,
  input  wire logic [TILE_ID_BITS-1:0] first_tile,
  input  wire logic [TILE_ID_BITS-1:0] tiles_wanted,
  input  wire logic [TILE_ID_BITS-1:0] a_depth_stride,
  input  wire logic [TILE_ID_BITS-1:0] a_batch_stride,
  input  wire logic [TILE_ID_BITS-1:0] a_channel_stride,
  input  wire logic [TILE_ID_BITS-1:0] b_depth_stride,
  input  wire logic [TILE_ID_BITS-1:0] b_batch_stride,
  input  wire logic [TILE_ID_BITS-1:0] b_channel_stride,
  output stpaw_pkg::status_t           status,
  output logic [TILE_ID_BITS-1:0]      pair_a,
  output logic [TILE_ID_BITS-1:0]      pair_b
);
  localparam int TB = TILE_ID_BITS;
  localparam int DB = DIM_BITS;
  localparam int PB = 4 * DB;
  localparam int CB = $clog2(TB + 1);

  logic [TB-1:0] st_ad, st_an, st_ac, st_bd, st_bn, st_bc, st_left;
  logic [PB-1:0] hw, per_batch, per_depth;
  logic [TB-1:0] num;
  logic [TB-1:0] quo;
  logic [PB:0]   rem;
  logic [PB-1:0] dvs;
  logic [CB-1:0] bit_cnt;
  logic [TB-1:0] d_q, n_q, c_q, th_q;
  logic [DB-1:0] tw_q;
  logic [TB-1:0] mul_x, mul_y;
  logic [TB-1:0] mul_p;

  logic          walk_active;
  logic [DB-1:0] depth_index, batch_index, channel_index, row_index, row_first_col;
  logic [DB:0]   col_index, row_end_col;
  logic [TB-1:0] offset_a, offset_b, tiles_left;
  logic [TB-1:0] shift_a [3];
  logic [TB-1:0] shift_b [3];

  logic [PB:0]   rem_sh;
  logic [PB-1:0] cur_dvs;
  logic [DB:0]   end_col;
  logic          dim_zero;

  always_comb begin
    cur_dvs = per_depth;
    case (cmd.sel)
      3'd0: cur_dvs = per_depth;
      3'd1: cur_dvs = per_batch;
      3'd2: cur_dvs = hw;
      default: cur_dvs = {{(PB-DB){1'b0}}, tile_cols};
    endcase
  end

  assign rem_sh = {rem[PB-1:0], num[TB-1]};
  assign status.div_last = (bit_cnt == CB'(TB - 1));
  assign end_col = shard_mode ? ({1'b0, tw_q} + {1'b0, shard_width}) : {1'b0, tile_cols};
  assign dim_zero = (batch_count == '0) || (channel_count == '0) || (tile_rows == '0);
  assign status.walk_ok = (st_left != '0) && (d_q < TB'(depth_count)) && !dim_zero &&
                          ({1'b0, tw_q} < end_col);
  assign status.active = walk_active;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (cmd.sel)
      3'd0: begin mul_x = d_q;  mul_y = st_ad; end
      3'd1: begin mul_x = n_q;  mul_y = st_an; end
      3'd2: begin mul_x = c_q;  mul_y = st_ac; end
      3'd3: begin mul_x = th_q; mul_y = TB'(tile_cols); end
      3'd4: begin mul_x = d_q;  mul_y = st_bd; end
      3'd5: begin mul_x = n_q;  mul_y = st_bn; end
      3'd6: begin mul_x = c_q;  mul_y = st_bc; end
      default: begin mul_x = th_q; mul_y = TB'(tile_cols); end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  // Step logic.
  logic [DB:0]   col_inc;
  logic [TB-1:0] oa_n, ob_n;
  logic [DB-1:0] row_n, ch_n, bt_n, dp_n;
  logic [DB:0]   col_n;
  logic [DB-1:0] first_n;
  logic          done;
  always_comb begin
    col_inc = col_index + 1'b1;
    oa_n = offset_a;
    ob_n = offset_b;
    row_n = row_index;
    ch_n = channel_index;
    bt_n = batch_index;
    dp_n = depth_index;
    col_n = col_inc;
    first_n = row_first_col;
    done = 1'b0;
    if (col_inc >= row_end_col) begin
      if (!shard_mode) first_n = '0;
      col_n = {1'b0, first_n};
      oa_n = offset_a + TB'(tile_cols);
      ob_n = offset_b + TB'(tile_cols);
      row_n = row_index + 1'b1;
      if (row_n >= tile_rows) begin
        row_n = '0;
        oa_n = oa_n + shift_a[0];
        ob_n = ob_n + shift_b[0];
        ch_n = channel_index + 1'b1;
        if (ch_n >= channel_count) begin
          ch_n = '0;
          oa_n = oa_n + shift_a[1];
          ob_n = ob_n + shift_b[1];
          bt_n = batch_index + 1'b1;
          if (bt_n >= batch_count) begin
            bt_n = '0;
            oa_n = oa_n + shift_a[2];
            ob_n = ob_n + shift_b[2];
            dp_n = depth_index + 1'b1;
            if (dp_n >= depth_count || dp_n == '0) done = 1'b1;
          end
        end
      end
    end
  end
  assign status.final_step = done || (tiles_left == TB'(1));
  assign pair_a = offset_a + TB'(col_index);
  assign pair_b = offset_b + TB'(col_index);

  always_ff @(posedge clk) begin
    case (cmd.op)
      stpaw_pkg::OP_LOAD: begin
        num <= first_tile;
        st_left <= tiles_wanted;
        st_ad <= a_depth_stride;
        st_an <= a_batch_stride;
        st_ac <= a_channel_stride;
        st_bd <= b_depth_stride;
        st_bn <= b_batch_stride;
        st_bc <= b_channel_stride;
      end
      stpaw_pkg::OP_SIZE_HW: hw <= PB'(tile_rows) * PB'(tile_cols);
      stpaw_pkg::OP_SIZE_PB: per_batch <= PB'(hw[2*DB-1:0]) * PB'(channel_count);
      stpaw_pkg::OP_SIZE_PD: per_depth <= PB'(per_batch[3*DB-1:0]) * PB'(batch_count);
      stpaw_pkg::OP_DIV_INIT: begin
        dvs <= cur_dvs;
        rem <= '0;
        quo <= '0;
        bit_cnt <= '0;
      end
      stpaw_pkg::OP_DIV_BIT: begin
        num <= {num[TB-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[TB-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[TB-2:0], 1'b0};
        end
      end
      stpaw_pkg::OP_DIV_DONE: begin
        // A zero divisor yields quotient and remainder zero.
        num <= (dvs == '0) ? '0 : TB'(rem);
        case (cmd.sel)
          3'd0: d_q <= (dvs == '0) ? '0 : quo;
          3'd1: n_q <= (dvs == '0) ? '0 : quo;
          3'd2: c_q <= (dvs == '0) ? '0 : quo;
          default: begin
            th_q <= (dvs == '0) ? '0 : quo;
            tw_q <= (dvs == '0) ? '0 : DB'(rem);
          end
        endcase
      end
      stpaw_pkg::OP_MUL_STEP: begin
        if (cmd.sel == 3'd0) offset_a <= mul_p;
        else if (cmd.sel < 3'd4) offset_a <= offset_a + mul_p;
        else if (cmd.sel == 3'd4) offset_b <= mul_p;
        else offset_b <= offset_b + mul_p;
      end
      stpaw_pkg::OP_FINISH: begin
        tiles_left <= st_left;
        row_first_col <= tw_q;
        row_end_col <= end_col;
        shift_a[0] <= st_ac - TB'(tile_rows) * TB'(tile_cols);
        shift_a[1] <= st_an - st_ac * TB'(channel_count);
        shift_a[2] <= st_ad - st_an * TB'(batch_count);
        shift_b[0] <= st_bc - TB'(tile_rows) * TB'(tile_cols);
        shift_b[1] <= st_bn - st_bc * TB'(channel_count);
        shift_b[2] <= st_bd - st_bn * TB'(batch_count);
        depth_index <= DB'(d_q);
        batch_index <= DB'(n_q);
        channel_index <= DB'(c_q);
        row_index <= DB'(th_q);
        col_index <= {1'b0, tw_q};
      end
      stpaw_pkg::OP_STEP: begin
        offset_a <= oa_n;
        offset_b <= ob_n;
        tiles_left <= tiles_left - 1'b1;
        col_index <= col_n;
        row_first_col <= first_n;
        row_index <= row_n;
        channel_index <= ch_n;
        batch_index <= bt_n;
        depth_index <= dp_n;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active <= 1'b0;
    end else if (cmd.op == stpaw_pkg::OP_LOAD) begin
      walk_active <= 1'b0;
    end else if (cmd.op == stpaw_pkg::OP_FINISH) begin
      walk_active <= status.walk_ok;
    end else if (cmd.op == stpaw_pkg::OP_STEP) begin
      walk_active <= !status.final_step;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/strided_tile_pair_address_walker_core.sv
// A step item gives its tile pair in the output register in the cycle after transfer.
// Throughput: one step item per cycle while the output register drains each cycle.
// A start item occupies the sequencer through the shape products, four divisions on the
// shared bit-serial divider, the products of the single offset multiplier and a finish step.
// Reset: synchronous, active high; registers return to 1, shard mode to 0, walk inactive.
// ----------------------------------------------------------------------------
// strided_tile_pair_address_walker_core
// Top level: stream ports, configuration registers, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "strided_tile_pair_address_walker_core_assert.svh"
module strided_tile_pair_address_walker_core #(
  parameter int TILE_ID_BITS = stpaw_pkg::TILE_ID_BITS,
  parameter int DIM_BITS = stpaw_pkg::DIM_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [stpaw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [DIM_BITS-1:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // tdata from bit 0: first_tile, tiles_wanted, a_depth_stride, a_batch_stride,
  // a_channel_stride, b_depth_stride, b_batch_stride, b_channel_stride.
  input  wire logic [8*TILE_ID_BITS-1:0] s_axis_tdata,
  input  wire logic s_axis_tuser,  // kind
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [2*TILE_ID_BITS-1:0] m_axis_tdata,  // tile_a, tile_b
  output logic      m_axis_tlast   // final_pair
);
  localparam int TB = TILE_ID_BITS;

  logic [DIM_BITS-1:0] depth_count, batch_count, channel_count;
  logic [DIM_BITS-1:0] tile_rows, tile_cols, shard_width;
  logic shard_mode;
  stpaw_pkg::cmd_t cmd;
  stpaw_pkg::status_t status;
  logic in_fire, out_load, out_free;
  logic [TB-1:0] pair_a, pair_b;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_count <= DIM_BITS'(1);
      batch_count <= DIM_BITS'(1);
      channel_count <= DIM_BITS'(1);
      tile_rows <= DIM_BITS'(1);
      tile_cols <= DIM_BITS'(1);
      shard_width <= DIM_BITS'(1);
      shard_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        stpaw_pkg::REG_DEPTH_COUNT:   depth_count <= cfg_data;
        stpaw_pkg::REG_BATCH_COUNT:   batch_count <= cfg_data;
        stpaw_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data;
        stpaw_pkg::REG_TILE_ROWS:     tile_rows <= cfg_data;
        stpaw_pkg::REG_TILE_COLS:     tile_cols <= cfg_data;
        stpaw_pkg::REG_SHARD_WIDTH:   shard_width <= cfg_data;
        stpaw_pkg::REG_SHARD_MODE:    shard_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  stpaw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_kind(s_axis_tuser),
    .out_free(out_free), .status(status), .in_ready(s_axis_tready),
    .out_load(out_load), .cmd(cmd)
  );

  stpaw_datapath #(.TILE_ID_BITS(TILE_ID_BITS), .DIM_BITS(DIM_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .depth_count(depth_count), .batch_count(batch_count),
    .channel_count(channel_count), .tile_rows(tile_rows), .tile_cols(tile_cols),
    .shard_width(shard_width), .shard_mode(shard_mode),
    .first_tile(s_axis_tdata[0*TB +: TB]), .tiles_wanted(s_axis_tdata[1*TB +: TB]),
    .a_depth_stride(s_axis_tdata[2*TB +: TB]), .a_batch_stride(s_axis_tdata[3*TB +: TB]),
    .a_channel_stride(s_axis_tdata[4*TB +: TB]), .b_depth_stride(s_axis_tdata[5*TB +: TB]),
    .b_batch_stride(s_axis_tdata[6*TB +: TB]), .b_channel_stride(s_axis_tdata[7*TB +: TB]),
    .status(status), .pair_a(pair_a), .pair_b(pair_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {pair_b, pair_a};
      m_axis_tlast <= status.final_step;
    end
  end

  `STPAW_ASSERT_ALWAYS(a_load_room, clk, rst, !out_load || out_free,
    "result loaded while output register is full")
  `STPAW_ASSERT_NEXT(a_last_ends, clk, rst, out_load && status.final_step,
    !status.active, "walk still active after final pair")
  `STPAW_ASSERT_ALWAYS(a_load_active, clk, rst, !out_load || status.active,
    "result issued without an active walk")
endmodule
`default_nettype wire
